>>> rtl/refcounted_pair_dedup_table_core_assert.svh
// assertion helpers shared by the table modules
`ifndef REFCOUNTED_PAIR_DEDUP_TABLE_CORE_ASSERT_SVH
`define REFCOUNTED_PAIR_DEDUP_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define RPDT_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpdt assertion failed");

// next-cycle implication, disabled while reset is held
`define RPDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpdt assertion failed");

`endif

>>> rtl/rpdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpdt_pkg;

    localparam int SLOTS      = 32;
    localparam int COUNT_BITS = 10;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int SPAN_BITS  = $clog2(SLOTS + 1);
    localparam int TILE_BITS  = 8;
    localparam int CODE_W     = 6;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_REL_UNUSED = 2'd2,
        ST_SAT        = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL,
        S_REL_UPD,
        S_SRCH,
        S_DECIDE,
        S_ALLOC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rel_check;
        logic rel_upd;
        logic srch_step;
        logic hit_upd;
        logic set_full;
        logic pop;
        logic alloc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic rel_go;
        logic srch_done;
        logic hit;
        logic stack_empty;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/rpdt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module rpdt_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire rpdt_pkg::t_cmd                  i_cmd,
    output rpdt_pkg::t_stat                      o_stat,
    input  wire logic                            i_action,
    input  wire logic [rpdt_pkg::TILE_BITS-1:0]  i_left_tile,
    input  wire logic [rpdt_pkg::TILE_BITS-1:0]  i_right_tile,
    input  wire logic [rpdt_pkg::CODE_W-1:0]     i_old_code,
    output logic      [rpdt_pkg::CODE_W-1:0]     o_code,
    output logic                                 o_new_entry,
    output logic                                 o_slot_freed,
    output logic      [1:0]                      o_status,
    output logic      [rpdt_pkg::CODE_W-1:0]     o_used_span,
    output logic      [rpdt_pkg::CODE_W-1:0]     o_allocated_count
);

`include "refcounted_pair_dedup_table_core_assert.svh"

    // item registers
    logic                                r_action;
    logic [rpdt_pkg::TILE_BITS-1:0]      r_left;
    logic [rpdt_pkg::TILE_BITS-1:0]      r_right;
    logic [rpdt_pkg::CODE_W-1:0]         r_old_code;

    // slot storage
    logic [2*rpdt_pkg::TILE_BITS-1:0]    r_pair_mem [rpdt_pkg::SLOTS];
    logic [rpdt_pkg::COUNT_BITS-1:0]     r_cnt_mem  [rpdt_pkg::SLOTS];
    logic [rpdt_pkg::SLOTS-1:0]          r_cnt_vld;
    logic [rpdt_pkg::SLOT_BITS-1:0]      r_stk_mem  [rpdt_pkg::SLOTS];
    logic [rpdt_pkg::SLOTS-1:0]          r_stk_vld;

    // registered read data
    logic [2*rpdt_pkg::TILE_BITS-1:0]    r_pair_rd;
    logic [rpdt_pkg::COUNT_BITS-1:0]     r_cnt_rd;
    logic                                r_cnt_rd_vld;
    logic [rpdt_pkg::SLOT_BITS-1:0]      r_stk_rd;
    logic [rpdt_pkg::SLOT_BITS-1:0]      r_stk_dflt;
    logic                                r_stk_rd_vld;

    // counters
    logic [rpdt_pkg::SPAN_BITS-1:0]      r_free_top;
    logic [rpdt_pkg::SPAN_BITS-1:0]      r_alloc_cnt;
    logic [rpdt_pkg::SPAN_BITS-1:0]      r_high_water;

    // search
    logic [rpdt_pkg::SPAN_BITS-1:0]      r_idx;
    logic                                r_cmp_vld;
    logic [rpdt_pkg::SLOT_BITS-1:0]      r_cmp_idx;
    logic                                r_hit;
    logic [rpdt_pkg::SLOT_BITS-1:0]      r_hit_slot;
    logic [rpdt_pkg::COUNT_BITS-1:0]     r_hit_cnt;

    // per-item results
    logic [rpdt_pkg::CODE_W-1:0]         r_code;
    logic                                r_new;
    logic                                r_freed;
    logic                                r_rel_bad;
    rpdt_pkg::t_status                   r_lk_st;

    logic [rpdt_pkg::SLOT_BITS-1:0]      rel_slot;
    logic                                rel_req;
    logic                                rel_in_range;
    logic [rpdt_pkg::SLOT_BITS-1:0]      rd_addr;
    logic [rpdt_pkg::SLOT_BITS-1:0]      stk_addr;
    logic [rpdt_pkg::COUNT_BITS-1:0]     cnt_eff;
    logic [rpdt_pkg::SLOT_BITS-1:0]      pop_slot;
    logic                                issue;
    logic                                pair_match;
    logic                                rel_frees;
    logic                                push_ok;
    logic [rpdt_pkg::SPAN_BITS-1:0]      n_alloc_cnt;

    logic                                cw_en;
    logic [rpdt_pkg::SLOT_BITS-1:0]      cw_addr;
    logic [rpdt_pkg::COUNT_BITS-1:0]     cw_data;

    assign rel_slot     = rpdt_pkg::SLOT_BITS'(r_old_code - rpdt_pkg::CODE_W'(1));
    assign rel_req      = r_action && (r_old_code != '0);
    assign rel_in_range = 32'(r_old_code) <= 32'(rpdt_pkg::SLOTS);
    assign rd_addr      = i_cmd.srch_step ? r_idx[rpdt_pkg::SLOT_BITS-1:0] : rel_slot;
    assign stk_addr     = rpdt_pkg::SLOT_BITS'(r_free_top - rpdt_pkg::SPAN_BITS'(1));
    assign cnt_eff      = r_cnt_rd_vld ? r_cnt_rd : '0;
    assign pop_slot     = r_stk_rd_vld ? r_stk_rd : r_stk_dflt;
    assign issue        = r_idx < r_high_water;
    assign pair_match   = r_cmp_vld && (cnt_eff != '0) && (r_pair_rd == {r_left, r_right});
    assign rel_frees    = i_cmd.rel_upd && (cnt_eff == rpdt_pkg::COUNT_BITS'(1));
    assign push_ok      = r_free_top < rpdt_pkg::SPAN_BITS'(rpdt_pkg::SLOTS);
    assign n_alloc_cnt  = r_alloc_cnt + rpdt_pkg::SPAN_BITS'(1);

    assign o_stat.rel_go      = rel_req && rel_in_range;
    assign o_stat.srch_done   = pair_match || !issue;
    assign o_stat.hit         = r_hit;
    assign o_stat.stack_empty = (r_free_top == '0);

    // single write port of the count memory
    always_comb begin
        cw_en   = 1'b0;
        cw_addr = rel_slot;
        cw_data = cnt_eff - rpdt_pkg::COUNT_BITS'(1);
        if (i_cmd.rel_upd && (cnt_eff != '0)) begin
            cw_en = 1'b1;
        end else if (i_cmd.hit_upd && (r_hit_cnt != rpdt_pkg::COUNT_MAX)) begin
            cw_en   = 1'b1;
            cw_addr = r_hit_slot;
            cw_data = r_hit_cnt + rpdt_pkg::COUNT_BITS'(1);
        end else if (i_cmd.alloc) begin
            cw_en   = 1'b1;
            cw_addr = pop_slot;
            cw_data = rpdt_pkg::COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cw_en) begin
            r_cnt_mem[cw_addr] <= cw_data;
        end
        if (i_cmd.alloc) begin
            r_pair_mem[pop_slot] <= {r_left, r_right};
        end
        if (rel_frees && push_ok) begin
            r_stk_mem[r_free_top[rpdt_pkg::SLOT_BITS-1:0]] <= rel_slot;
        end
        r_pair_rd    <= r_pair_mem[rd_addr];
        r_cnt_rd     <= r_cnt_mem[rd_addr];
        r_cnt_rd_vld <= r_cnt_vld[rd_addr];
        r_stk_rd     <= r_stk_mem[stk_addr];
        r_stk_rd_vld <= r_stk_vld[stk_addr];
        r_stk_dflt   <= rpdt_pkg::SLOT_BITS'(rpdt_pkg::SLOTS - 1) - stk_addr;
    end

    // entries without a valid bit read as their reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_stk_vld <= '0;
        end else begin
            if (cw_en) begin
                r_cnt_vld[cw_addr] <= 1'b1;
            end
            if (rel_frees && push_ok) begin
                r_stk_vld[r_free_top[rpdt_pkg::SLOT_BITS-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_top   <= rpdt_pkg::SPAN_BITS'(rpdt_pkg::SLOTS);
            r_alloc_cnt  <= '0;
            r_high_water <= '0;
        end else if (rel_frees) begin
            if (push_ok) begin
                r_free_top <= r_free_top + rpdt_pkg::SPAN_BITS'(1);
            end
            if (r_alloc_cnt != '0) begin
                r_alloc_cnt <= r_alloc_cnt - rpdt_pkg::SPAN_BITS'(1);
            end
        end else if (i_cmd.pop) begin
            r_free_top <= r_free_top - rpdt_pkg::SPAN_BITS'(1);
        end else if (i_cmd.alloc) begin
            r_alloc_cnt <= n_alloc_cnt;
            if (n_alloc_cnt > r_high_water) begin
                r_high_water <= n_alloc_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_code    <= '0;
            r_new     <= 1'b0;
            r_freed   <= 1'b0;
            r_rel_bad <= 1'b0;
            r_lk_st   <= rpdt_pkg::ST_OK;
        end else if (i_cmd.load) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_code    <= '0;
            r_new     <= 1'b0;
            r_freed   <= 1'b0;
            r_rel_bad <= 1'b0;
            r_lk_st   <= rpdt_pkg::ST_OK;
        end else begin
            if (i_cmd.rel_check && rel_req && !rel_in_range) begin
                r_rel_bad <= 1'b1;
            end
            if (i_cmd.rel_upd && (cnt_eff == '0)) begin
                r_rel_bad <= 1'b1;
            end
            if (rel_frees) begin
                r_freed <= 1'b1;
            end
            // one slot issued and one compared per cycle
            if (i_cmd.srch_step) begin
                r_cmp_vld <= issue && !pair_match;
                r_cmp_idx <= r_idx[rpdt_pkg::SLOT_BITS-1:0];
                if (issue && !pair_match) begin
                    r_idx <= r_idx + rpdt_pkg::SPAN_BITS'(1);
                end
                if (pair_match) begin
                    r_hit      <= 1'b1;
                    r_hit_slot <= r_cmp_idx;
                    r_hit_cnt  <= cnt_eff;
                end
            end
            if (i_cmd.hit_upd) begin
                r_code <= rpdt_pkg::CODE_W'({1'b0, r_hit_slot} + 1'b1);
                if (r_hit_cnt == rpdt_pkg::COUNT_MAX) begin
                    r_lk_st <= rpdt_pkg::ST_SAT;
                end
            end
            if (i_cmd.set_full) begin
                r_lk_st <= rpdt_pkg::ST_FULL;
            end
            if (i_cmd.alloc) begin
                r_code <= rpdt_pkg::CODE_W'({1'b0, pop_slot} + 1'b1);
                r_new  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_action;
            r_left     <= i_left_tile;
            r_right    <= i_right_tile;
            r_old_code <= i_old_code;
        end
        if (i_cmd.out_load) begin
            o_code            <= r_code;
            o_new_entry       <= r_new;
            o_slot_freed      <= r_freed;
            o_used_span       <= rpdt_pkg::CODE_W'(r_high_water);
            o_allocated_count <= rpdt_pkg::CODE_W'(r_alloc_cnt);
            if (r_lk_st != rpdt_pkg::ST_OK) begin
                o_status <= r_lk_st;
            end else if (r_rel_bad) begin
                o_status <= rpdt_pkg::ST_REL_UNUSED;
            end else begin
                o_status <= rpdt_pkg::ST_OK;
            end
        end
    end

    // a pop comes in the cycle before its alloc, so the sum is one short while alloc is up
    `RPDT_ASSERT(a_stack_balance, i_clk, i_rst_n, !i_cmd.alloc, (r_free_top + r_alloc_cnt) == rpdt_pkg::SLOTS)
    `RPDT_ASSERT(a_alloc_le_span, i_clk, i_rst_n, 1'b1, r_alloc_cnt <= r_high_water)
    `RPDT_ASSERT(a_pop_nonempty, i_clk, i_rst_n, i_cmd.pop, r_free_top != '0)

endmodule

`default_nettype wire

>>> rtl/rpdt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rpdt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  wire rpdt_pkg::t_stat i_stat,
    output rpdt_pkg::t_cmd       o_cmd
);

`include "refcounted_pair_dedup_table_core_assert.svh"

    rpdt_pkg::t_state r_state;
    rpdt_pkg::t_state n_state;
    logic             r_out_valid;
    logic             out_free;

    assign o_in_stall  = (r_state != rpdt_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpdt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            rpdt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rpdt_pkg::S_REL;
                end
            end
            rpdt_pkg::S_REL: begin
                o_cmd.rel_check = 1'b1;
                n_state = i_stat.rel_go ? rpdt_pkg::S_REL_UPD : rpdt_pkg::S_SRCH;
            end
            rpdt_pkg::S_REL_UPD: begin
                o_cmd.rel_upd = 1'b1;
                n_state       = rpdt_pkg::S_SRCH;
            end
            rpdt_pkg::S_SRCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_stat.srch_done) begin
                    n_state = rpdt_pkg::S_DECIDE;
                end
            end
            rpdt_pkg::S_DECIDE: begin
                priority if (i_stat.hit) begin
                    o_cmd.hit_upd = 1'b1;
                    n_state       = rpdt_pkg::S_OUT;
                end else if (i_stat.stack_empty) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = rpdt_pkg::S_OUT;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = rpdt_pkg::S_ALLOC;
                end
            end
            rpdt_pkg::S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = rpdt_pkg::S_OUT;
            end
            rpdt_pkg::S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rpdt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rpdt_pkg::S_IDLE;
            end
        endcase
    end

    // output register: filled by the controller, drained by the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    `RPDT_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && (r_state == rpdt_pkg::S_IDLE), r_state == rpdt_pkg::S_REL)
    `RPDT_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, o_cmd.out_load, r_out_valid)
    `RPDT_ASSERT(a_alloc_after_pop, i_clk, i_rst_n, r_state == rpdt_pkg::S_ALLOC, $past(r_state) == rpdt_pkg::S_DECIDE)

endmodule

`default_nettype wire

>>> rtl/refcounted_pair_dedup_table_core.sv
// from input transaction to o_out_valid: release check, optional release update, search, decide,
// optional alloc, output; the search reads one slot per cycle from the pair/count memories
// throughput: one item at a time, the next accepted the cycle after the result is registered
// reset: synchronous, active low; all counters clear at once, and counts read zero and the
// free stack is full through per-entry valid bits, so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module refcounted_pair_dedup_table_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_action,
    input  wire logic [rpdt_pkg::TILE_BITS-1:0]  i_left_tile,
    input  wire logic [rpdt_pkg::TILE_BITS-1:0]  i_right_tile,
    input  wire logic [rpdt_pkg::CODE_W-1:0]     i_old_code,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [rpdt_pkg::CODE_W-1:0]     o_code,
    output logic                                 o_new_entry,
    output logic                                 o_slot_freed,
    output logic      [1:0]                      o_status,
    output logic      [rpdt_pkg::CODE_W-1:0]     o_used_span,
    output logic      [rpdt_pkg::CODE_W-1:0]     o_allocated_count
);

    rpdt_pkg::t_cmd  cmd;
    rpdt_pkg::t_stat stat;

    rpdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rpdt_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_action          (i_action),
        .i_left_tile       (i_left_tile),
        .i_right_tile      (i_right_tile),
        .i_old_code        (i_old_code),
        .o_code            (o_code),
        .o_new_entry       (o_new_entry),
        .o_slot_freed      (o_slot_freed),
        .o_status          (o_status),
        .o_used_span       (o_used_span),
        .o_allocated_count (o_allocated_count)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [rpdt_pkg::CODE_W-1:0] code;
        logic                        new_entry;
        logic                        slot_freed;
        rpdt_pkg::t_status           status;
        logic [rpdt_pkg::CODE_W-1:0] used_span;
        logic [rpdt_pkg::CODE_W-1:0] allocated_count;
    } t_slot_result;

    class dedup_scoreboard;
        logic [rpdt_pkg::TILE_BITS-1:0]  left_of[rpdt_pkg::SLOTS];
        logic [rpdt_pkg::TILE_BITS-1:0]  right_of[rpdt_pkg::SLOTS];
        logic [rpdt_pkg::COUNT_BITS-1:0] refs[rpdt_pkg::SLOTS];
        int                              free_slots[rpdt_pkg::SLOTS];
        int                              free_top;
        int                              live_slots;
        int                              span;
        t_slot_result                    pending_results[$];
        int                              errors;

        function new();
            for (int i = 0; i < rpdt_pkg::SLOTS; i++) begin
                left_of[i]    = '0;
                right_of[i]   = '0;
                refs[i]       = '0;
                free_slots[i] = rpdt_pkg::SLOTS - 1 - i;
            end
            free_top   = rpdt_pkg::SLOTS;
            live_slots = 0;
            span       = 0;
            errors     = 0;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return pending_results.size();
        endfunction

        // applies one accepted transaction and returns the code it should produce
        function logic [rpdt_pkg::CODE_W-1:0] record_pair(input logic act,
                                                input logic [rpdt_pkg::TILE_BITS-1:0] lt,
                                                input logic [rpdt_pkg::TILE_BITS-1:0] rt,
                                                input logic [rpdt_pkg::CODE_W-1:0] old);
            t_slot_result      r;
            rpdt_pkg::t_status lookup;
            int                slot;
            bit                hit;

            r.code       = '0;
            r.new_entry  = 1'b0;
            r.slot_freed = 1'b0;
            r.status     = rpdt_pkg::ST_OK;
            lookup       = rpdt_pkg::ST_OK;
            hit          = 1'b0;

            if (act && old != 0) begin
                slot = int'(old) - 1;
                if (slot >= rpdt_pkg::SLOTS || refs[slot] == 0) begin
                    r.status = rpdt_pkg::ST_REL_UNUSED;
                end else begin
                    refs[slot] = refs[slot] - 1'b1;
                    if (refs[slot] == 0) begin
                        left_of[slot] = 8'hff;
                        if (free_top < rpdt_pkg::SLOTS) begin
                            free_slots[free_top] = slot;
                            free_top++;
                        end
                        if (live_slots > 0)
                            live_slots--;
                        r.slot_freed = 1'b1;
                    end
                end
            end

            // lowest live match below the high-water mark wins
            for (int i = 0; i < span && i < rpdt_pkg::SLOTS; i++) begin
                if (!hit && refs[i] != 0 && left_of[i] == lt && right_of[i] == rt) begin
                    hit = 1'b1;
                    if (refs[i] == rpdt_pkg::COUNT_MAX)
                        lookup = rpdt_pkg::ST_SAT;
                    else
                        refs[i] = refs[i] + 1'b1;
                    r.code = rpdt_pkg::CODE_W'(i + 1);
                end
            end

            if (!hit) begin
                if (free_top == 0) begin
                    lookup = rpdt_pkg::ST_FULL;
                end else begin
                    free_top--;
                    slot = free_slots[free_top];
                    live_slots++;
                    if (live_slots > span)
                        span = live_slots;
                    refs[slot]     = 1;
                    left_of[slot]  = lt;
                    right_of[slot] = rt;
                    r.new_entry    = 1'b1;
                    r.code         = rpdt_pkg::CODE_W'(slot + 1);
                end
            end

            if (lookup != rpdt_pkg::ST_OK)
                r.status = lookup;
            r.used_span       = rpdt_pkg::CODE_W'(span);
            r.allocated_count = rpdt_pkg::CODE_W'(live_slots);
            pending_results.push_back(r);
            return r.code;
        endfunction

        task check_result(input logic [rpdt_pkg::CODE_W-1:0] code, input logic new_entry,
                          input logic slot_freed, input logic [1:0] status,
                          input logic [rpdt_pkg::CODE_W-1:0] used_span,
                          input logic [rpdt_pkg::CODE_W-1:0] allocated_count);
            t_slot_result e;
            if (pending_results.size() == 0) begin
                report("result transaction with nothing pending");
            end else begin
                e = pending_results.pop_front();
                if (code !== e.code)
                    report($sformatf("code %0d, want %0d", code, e.code));
                if (new_entry !== e.new_entry)
                    report($sformatf("new_entry %b, want %b", new_entry, e.new_entry));
                if (slot_freed !== e.slot_freed)
                    report($sformatf("slot_freed %b, want %b", slot_freed, e.slot_freed));
                if (status !== e.status)
                    report($sformatf("status %0d, want %0d", status, e.status));
                if (used_span !== e.used_span)
                    report($sformatf("used_span %0d, want %0d", used_span, e.used_span));
                if (allocated_count !== e.allocated_count)
                    report($sformatf("allocated_count %0d, want %0d",
                                     allocated_count, e.allocated_count));
            end
        endtask
    endclass

    logic                            i_clk             = 1'b0;
    logic                            i_rst_n           = 1'b0;
    logic                            i_in_valid        = 1'b0;
    logic                            i_action          = 1'b0;
    logic [rpdt_pkg::TILE_BITS-1:0]  i_left_tile       = '0;
    logic [rpdt_pkg::TILE_BITS-1:0]  i_right_tile      = '0;
    logic [rpdt_pkg::CODE_W-1:0]     i_old_code        = '0;
    logic                            i_out_stall       = 1'b0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic [rpdt_pkg::CODE_W-1:0]     o_code;
    logic                            o_new_entry;
    logic                            o_slot_freed;
    logic [1:0]                      o_status;
    logic [rpdt_pkg::CODE_W-1:0]     o_used_span;
    logic [rpdt_pkg::CODE_W-1:0]     o_allocated_count;

    logic                            quiet = 1'b0;
    dedup_scoreboard                 sb    = new();

    refcounted_pair_dedup_table_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_left_tile       (i_left_tile),
        .i_right_tile      (i_right_tile),
        .i_old_code        (i_old_code),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_code            (o_code),
        .o_new_entry       (o_new_entry),
        .o_slot_freed      (o_slot_freed),
        .o_status          (o_status),
        .o_used_span       (o_used_span),
        .o_allocated_count (o_allocated_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check accepted transactions, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_code, o_new_entry, o_slot_freed, o_status,
                                o_used_span, o_allocated_count);
            i_out_stall <= !quiet && ($urandom_range(99) < 7);
        end
    end

    task send_item(input logic act, input logic [rpdt_pkg::TILE_BITS-1:0] lt,
                   input logic [rpdt_pkg::TILE_BITS-1:0] rt,
                   input logic [rpdt_pkg::CODE_W-1:0] old,
                   output logic [rpdt_pkg::CODE_W-1:0] code);
        if (!quiet && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_left_tile  <= lt;
        i_right_tile <= rt;
        i_old_code   <= old;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        code = sb.record_pair(act, lt, rt, old);
    endtask

    initial begin
        logic [rpdt_pkg::CODE_W-1:0]    code;
        logic [rpdt_pkg::CODE_W-1:0]    screen[48];
        logic [rpdt_pkg::TILE_BITS-1:0] pool_left[64];
        logic [rpdt_pkg::TILE_BITS-1:0] pool_right[64];
        int                             pick;
        int                             pos;
        int                             guard;

        for (int i = 0; i < 48; i++)
            screen[i] = '0;
        for (int i = 0; i < 64; i++) begin
            pool_left[i]  = rpdt_pkg::TILE_BITS'($urandom);
            pool_right[i] = rpdt_pkg::TILE_BITS'($urandom);
        end
        pool_left[0]  = 8'h00;
        pool_right[0] = 8'h00;
        pool_left[1]  = 8'hff;
        pool_right[1] = 8'hff;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, missing and out-of-range release codes, free and reuse
        send_item(1'b0, 8'h00, 8'h00, 6'd0, code);
        send_item(1'b0, 8'h00, 8'h00, 6'd0, code);
        send_item(1'b0, 8'hff, 8'hff, 6'd0, code);
        send_item(1'b1, 8'hff, 8'hff, 6'd0, code);
        send_item(1'b1, 8'h01, 8'h02, 6'd40, code);
        send_item(1'b1, 8'h00, 8'h00, 6'd63, code);
        send_item(1'b1, 8'h00, 8'h00, 6'd32, code);
        send_item(1'b1, 8'h01, 8'h02, 6'd3, code);
        // freed slot keeps its right tile, left becomes the freed mark
        send_item(1'b1, 8'hff, 8'h02, 6'd3, code);
        send_item(1'b1, 8'haa, 8'h55, 6'd3, code);
        send_item(1'b0, 8'h55, 8'haa, 6'd0, code);
        send_item(1'b1, 8'h55, 8'haa, 6'd4, code);
        send_item(1'b1, 8'haa, 8'h55, 6'd1, code);
        send_item(1'b0, 8'h0f, 8'hf0, 6'd0, code);
        send_item(1'b1, 8'hf0, 8'h0f, 6'd5, code);
        send_item(1'b1, 8'h0f, 8'hf0, 6'd5, code);
        send_item(1'b1, 8'h0f, 8'hf0, 6'd0, code);

        // drive the zero pair to a saturated count
        repeat (1030)
            send_item(1'b0, 8'h00, 8'h00, 6'd0, code);
        send_item(1'b1, 8'h00, 8'h00, 6'd1, code);
        send_item(1'b0, 8'h00, 8'h00, 6'd0, code);
        send_item(1'b1, 8'h00, 8'h00, 6'd50, code);

        // random: screen positions swap pair codes, with stray lookups and noise
        for (int n = 0; n < 550; n++) begin
            quiet <= (n >= 150 && n < 400);
            pick = $urandom_range(99);
            if (pick < 82) begin
                pos = $urandom_range(47);
                pick = $urandom_range(63);
                send_item(1'b1, pool_left[pick], pool_right[pick], screen[pos], code);
                screen[pos] = code;
            end else if (pick < 87) begin
                pick = $urandom_range(63);
                send_item(1'b0, pool_left[pick], pool_right[pick], 6'd0, code);
            end else begin
                send_item(1'($urandom), rpdt_pkg::TILE_BITS'($urandom),
                          rpdt_pkg::TILE_BITS'($urandom),
                          rpdt_pkg::CODE_W'($urandom_range(63)), code);
            end
        end
        i_in_valid <= 1'b0;
        quiet      <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("refcounted_pair_dedup_table_core test passed");
        else
            $display("refcounted_pair_dedup_table_core test failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("refcounted_pair_dedup_table_core test failed");
        $finish;
    end

endmodule

>>> refcounted_pair_dedup_table_core.f
+incdir+rtl
rtl/rpdt_pkg.sv
rtl/rpdt_dpath.sv
rtl/rpdt_ctrl.sv
rtl/refcounted_pair_dedup_table_core.sv
tb/tb.sv
